// ===== design/wbr_pkg.sv =====
// ----------------------------------------------------------------------------
// wbr_pkg
// shared constants and the arctangent table for the waypoint bearing and range
// block
// ----------------------------------------------------------------------------
package wbr_pkg;

	localparam int ACC_W         = 32;
	localparam int CORDIC_GUARD  = 24;
	localparam int ATAN_ENTRIES  = 24;
	localparam int TOL_RESET     = 1024;

	localparam logic [ACC_W-1:0] Z_POS_QUARTER = 32'h4000_0000;
	localparam logic [ACC_W-1:0] Z_NEG_QUARTER = 32'hC000_0000;

	// atan(2^-idx), 2^31 = pi
	function automatic logic [ACC_W-1:0] atan_entry(input int idx);
		logic [ACC_W-1:0] val;
		unique case (idx)
			0:       val = 32'h2000_0000;
			1:       val = 32'h12E4_051E;
			2:       val = 32'h09FB_385B;
			3:       val = 32'h0511_11D4;
			4:       val = 32'h028B_0D43;
			5:       val = 32'h0145_D7E1;
			6:       val = 32'h00A2_F61E;
			7:       val = 32'h0051_7C55;
			8:       val = 32'h0028_BE53;
			9:       val = 32'h0014_5F2F;
			10:      val = 32'h000A_2F98;
			11:      val = 32'h0005_17CC;
			12:      val = 32'h0002_8BE6;
			13:      val = 32'h0001_45F3;
			14:      val = 32'h0000_A2FA;
			15:      val = 32'h0000_517D;
			16:      val = 32'h0000_28BE;
			17:      val = 32'h0000_145F;
			18:      val = 32'h0000_0A30;
			19:      val = 32'h0000_0518;
			20:      val = 32'h0000_028C;
			21:      val = 32'h0000_0146;
			22:      val = 32'h0000_00A3;
			23:      val = 32'h0000_0051;
			default: val = '0;
		endcase
		return val;
	endfunction

endpackage

// ===== design/wbr_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// wbr_cordic_cell
// one vectoring rotation of the bearing chain, registered
// ----------------------------------------------------------------------------
module wbr_cordic_cell #(
	parameter int CW  = 51,
	parameter int IDX = 0
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [CW-1:0]            x_in,
	input  logic signed [CW-1:0]            y_in,
	input  logic [wbr_pkg::ACC_W-1:0]       z_in,
	output logic signed [CW-1:0]            x_out,
	output logic signed [CW-1:0]            y_out,
	output logic [wbr_pkg::ACC_W-1:0]       z_out
);

	localparam logic [wbr_pkg::ACC_W-1:0] ANG = wbr_pkg::atan_entry(IDX);

	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;

	assign xs = x_in >>> IDX;
	assign ys = y_in >>> IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[CW-1]) begin
				x_out <= x_in + ys;
				y_out <= y_in - xs;
				z_out <= z_in + ANG;
			end else begin
				x_out <= x_in - ys;
				y_out <= y_in + xs;
				z_out <= z_in - ANG;
			end
		end
	end

endmodule

// ===== design/wbr_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// wbr_sqrt_cell
// one result bit of the digit-by-digit square root, registered
// ----------------------------------------------------------------------------
module wbr_sqrt_cell #(
	parameter int P = 24
) (
	input  logic                clk,
	input  logic                en,
	input  logic [P+2:0]        rem_in,
	input  logic [P:0]          r_in,
	input  logic [2*P+1:0]      rad_in,
	output logic [P+2:0]        rem_out,
	output logic [P:0]          r_out,
	output logic [2*P+1:0]      rad_out
);

	localparam int RW   = P + 3;
	localparam int RDW  = P + 1;
	localparam int RADW = 2 * P + 2;

	logic [RW-1:0] rem_sh;
	logic [RW-1:0] trial;
	logic          ge;

	assign rem_sh = {rem_in[RW-3:0], rad_in[RADW-1 -: 2]};
	assign trial  = {r_in, 2'b01};
	assign ge     = (rem_sh >= trial);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= ge ? (rem_sh - trial) : rem_sh;
			r_out   <= {r_in[RDW-2:0], ge};
			rad_out <= {rad_in[RADW-3:0], 2'b00};
		end
	end

endmodule

// ===== design/wbr_delay.sv =====
// ----------------------------------------------------------------------------
// wbr_delay
// enabled shift line that aligns a value with the longer pipeline branch
// ----------------------------------------------------------------------------
module wbr_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	generate
		if (DEPTH == 0) begin : g_none
			assign q = d;
		end else begin : g_line
			logic [WIDTH-1:0] tap_q [DEPTH];
			always_ff @(posedge clk) begin
				if (en) begin
					tap_q[0] <= d;
					for (int k = 1; k < DEPTH; k++) begin
						tap_q[k] <= tap_q[k-1];
					end
				end
			end
			assign q = tap_q[DEPTH-1];
		end
	endgenerate

endmodule

// ===== design/waypoint_bearing_range.sv =====
// ----------------------------------------------------------------------------
// waypoint_bearing_range
// range and signed turn angle from a pose to a waypoint, arrival flag
// ----------------------------------------------------------------------------
// throughput: one transfer per cycle while m_axis_tready does not stall the output, set by the
//   square root cell chain and the cordic cell chain, one cell per result bit or rotation
// reset: arrive_tolerance returns to 1024 (0.25 m), pipeline and output empty
// ----------------------------------------------------------------------------
module waypoint_bearing_range #(
	parameter int POSITION_WIDTH = 24,
	parameter int ANGLE_WIDTH    = 16,
	parameter int CORDIC_STAGES  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_wr_en,
	input  logic [POSITION_WIDTH-2:0]     cfg_wr_data,

	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// robot_x, robot_y, robot_yaw, target_x, target_y, zero fill
	input  logic [((4*POSITION_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,

	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// turn_angle, range, at_target, zero fill
	output logic [((POSITION_WIDTH+ANGLE_WIDTH+2+7)/8)*8-1:0] m_axis_tdata,
	// degenerate
	output logic                          m_axis_tuser
);

	localparam int P      = POSITION_WIDTH;
	localparam int A      = ANGLE_WIDTH;
	localparam int S      = CORDIC_STAGES;
	localparam int G      = wbr_pkg::CORDIC_GUARD;
	localparam int AW     = wbr_pkg::ACC_W;
	localparam int CW     = P + 1 + G + 2;
	localparam int RW     = P + 3;
	localparam int RADW   = 2 * P + 2;
	localparam int OUT_F  = A + P + 2;
	localparam int OUT_W  = ((OUT_F + 7) / 8) * 8;
	localparam int L_COR  = S + 2;
	localparam int L_SQR  = P + 4;
	localparam int L      = (L_COR > L_SQR) ? L_COR : L_SQR;
	localparam logic [AW-1:0] Z_HALF = AW'(1) << (AW - 1 - A);

	// configuration
	logic [P-2:0] tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= (P-1)'(wbr_pkg::TOL_RESET);
		end else if (cfg_wr_en) begin
			tol_q <= cfg_wr_data;
		end
	end

	// pipeline control
	logic [L-1:0] vld_q;
	logic         out_valid_q;
	logic         out_en;
	logic         en;

	assign out_en        = ~out_valid_q | m_axis_tready;
	assign en            = ~vld_q[L-1] | out_en;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], s_axis_tvalid};
		end
	end

	// stage 1: offsets
	logic [P-1:0]        rx, ry, tx, ty;
	logic [A-1:0]        yaw_in;
	logic signed [P:0]   dx_s1, dy_s1;
	logic [A-1:0]        yaw_s1;

	assign rx     = s_axis_tdata[P-1:0];
	assign ry     = s_axis_tdata[2*P-1:P];
	assign yaw_in = s_axis_tdata[2*P+A-1:2*P];
	assign tx     = s_axis_tdata[3*P+A-1:2*P+A];
	assign ty     = s_axis_tdata[4*P+A-1:3*P+A];

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= $signed({tx[P-1], tx}) - $signed({rx[P-1], rx});
			dy_s1  <= $signed({ty[P-1], ty}) - $signed({ry[P-1], ry});
			yaw_s1 <= yaw_in;
		end
	end

	// stage 2: squares, arrival and degenerate flags
	logic [P:0]      dx_neg, dy_neg;
	logic [P-1:0]    ax, ay;
	logic [2*P-1:0]  sx_s2, sy_s2;
	logic            at_s2, degen_s2;

	assign dx_neg = -dx_s1;
	assign dy_neg = -dy_s1;
	assign ax     = dx_s1[P] ? dx_neg[P-1:0] : dx_s1[P-1:0];
	assign ay     = dy_s1[P] ? dy_neg[P-1:0] : dy_s1[P-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s2    <= (2*P)'(ax) * (2*P)'(ax);
			sy_s2    <= (2*P)'(ay) * (2*P)'(ay);
			at_s2    <= (ax < {1'b0, tol_q}) && (ay < {1'b0, tol_q});
			degen_s2 <= (dx_s1 == '0) && (dy_s1 == '0);
		end
	end

	// stage 3: radicand
	logic [2*P:0] sum_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= {1'b0, sx_s2} + {1'b0, sy_s2};
		end
	end

	// cordic chain, quadrant fold ahead of the first cell
	logic signed [CW-1:0] x0, y0, xi, yi;
	logic [AW-1:0]        zi;
	logic signed [CW-1:0] cx [S+1];
	logic signed [CW-1:0] cy [S+1];
	logic [AW-1:0]        cz [S+1];

	assign x0 = {{(CW-P-1-G){dx_s1[P]}}, dx_s1, {G{1'b0}}};
	assign y0 = {{(CW-P-1-G){dy_s1[P]}}, dy_s1, {G{1'b0}}};

	always_comb begin
		xi = x0;
		yi = y0;
		zi = '0;
		if (dx_s1[P]) begin
			if (!dy_s1[P]) begin
				xi = y0;
				yi = -x0;
				zi = wbr_pkg::Z_POS_QUARTER;
			end else begin
				xi = -y0;
				yi = x0;
				zi = wbr_pkg::Z_NEG_QUARTER;
			end
		end
	end

	assign cx[0] = xi;
	assign cy[0] = yi;
	assign cz[0] = zi;

	generate
		for (genvar i = 0; i < S; i++) begin : g_cordic
			wbr_cordic_cell #(.CW(CW), .IDX(i)) u_cell (
				.clk   (clk),
				.en    (en),
				.x_in  (cx[i]),
				.y_in  (cy[i]),
				.z_in  (cz[i]),
				.x_out (cx[i+1]),
				.y_out (cy[i+1]),
				.z_out (cz[i+1])
			);
		end
	endgenerate

	// turn angle
	logic [A-1:0]  yaw_al;
	logic [AW-1:0] z_rnd;
	logic [A-1:0]  turn_q;
	logic [A-1:0]  turn_al;

	wbr_delay #(.WIDTH(A), .DEPTH(S)) u_yaw_dly (
		.clk (clk),
		.en  (en),
		.d   (yaw_s1),
		.q   (yaw_al)
	);

	assign z_rnd = cz[S] + Z_HALF;

	always_ff @(posedge clk) begin
		if (en) begin
			turn_q <= z_rnd[AW-1 -: A] - yaw_al;
		end
	end

	wbr_delay #(.WIDTH(A), .DEPTH(L - L_COR)) u_turn_dly (
		.clk (clk),
		.en  (en),
		.d   (turn_q),
		.q   (turn_al)
	);

	// square root chain
	logic [RW-1:0]   srem [P+2];
	logic [P:0]      sr   [P+2];
	logic [RADW-1:0] srad [P+2];

	assign srem[0] = '0;
	assign sr[0]   = '0;
	assign srad[0] = {1'b0, sum_s3};

	generate
		for (genvar j = 0; j <= P; j++) begin : g_sqrt
			wbr_sqrt_cell #(.P(P)) u_cell (
				.clk     (clk),
				.en      (en),
				.rem_in  (srem[j]),
				.r_in    (sr[j]),
				.rad_in  (srad[j]),
				.rem_out (srem[j+1]),
				.r_out   (sr[j+1]),
				.rad_out (srad[j+1])
			);
		end
	endgenerate

	logic [RW-1:0] rem_al;
	logic [P:0]    r_al;
	logic [P:0]    range_rnd;

	wbr_delay #(.WIDTH(RW + P + 1), .DEPTH(L - L_SQR)) u_sqrt_dly (
		.clk (clk),
		.en  (en),
		.d   ({srem[P+1], sr[P+1]}),
		.q   ({rem_al, r_al})
	);

	assign range_rnd = (rem_al > {2'b00, r_al}) ? (r_al + (P+1)'(1)) : r_al;

	// flags
	logic at_al, degen_al;

	wbr_delay #(.WIDTH(2), .DEPTH(L - 2)) u_flag_dly (
		.clk (clk),
		.en  (en),
		.d   ({at_s2, degen_s2}),
		.q   ({at_al, degen_al})
	);

	// output register
	logic [OUT_W-1:0] tdata_q;
	logic             tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= vld_q[L-1];
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			tdata_q <= OUT_W'({at_al, range_rnd, (degen_al ? {A{1'b0}} : turn_al)});
			tuser_q <= degen_al;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tuser  = tuser_q;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks waypoint_bearing_range against a behavioral model of the pose to
// waypoint math. Each transfer is predicted as it is accepted: rounded
// distance, cordic bearing minus yaw, and the arrival and same-spot flags.
// A directed table is followed by random poses under several arrival
// tolerances, with random gaps and back pressure on both streams.
// ----------------------------------------------------------------------------
module testbench;

	localparam int POS_W       = 24;
	localparam int ANG_W       = 16;
	localparam int STAGES      = 16;
	localparam int GUARD       = 24;
	localparam int IN_W        = ((4*POS_W+ANG_W+7)/8)*8;
	localparam int OUT_W       = ((POS_W+ANG_W+2+7)/8)*8;
	localparam int DRAIN       = 40;
	localparam int PHASE_ITEMS = 170;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;
	localparam longint unsigned RANGE_MAX = (64'd1 << (POS_W + 1)) - 1;

	typedef struct packed {
		logic signed [POS_W-1:0] rx;
		logic signed [POS_W-1:0] ry;
		logic signed [ANG_W-1:0] yaw;
		logic signed [POS_W-1:0] tx;
		logic signed [POS_W-1:0] ty;
	} pose_t;

	typedef struct packed {
		logic [ANG_W-1:0] turn;
		logic [POS_W:0]   range_q12;
		logic             arrived;
		logic             degen;
	} nav_t;

	typedef struct {
		pose_t pose;
		bit    typed;
		nav_t  want;
	} pose_row_t;

	localparam nav_t NAV_SAME_SPOT = '{turn: '0, range_q12: '0, arrived: 1'b1, degen: 1'b1};

	logic               clk;
	logic               arst_n        = 1'b0;
	logic               cfg_wr_en     = 1'b0;
	logic [POS_W-2:0]   cfg_wr_data   = '0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [IN_W-1:0]    s_axis_tdata  = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [OUT_W-1:0]   m_axis_tdata;
	logic               m_axis_tuser;

	logic [31:0] atan_q31 [16] = '{
		32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
		32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
		32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
		32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
	};

	logic [POS_W-2:0] arrive_tol = 23'(wbr_pkg::TOL_RESET);
	nav_t             nav_due [$];
	int               mismatches  = 0;
	int               cycle_count = 0;
	bit               quiet       = 1'b0;

	waypoint_bearing_range #(
		.POSITION_WIDTH (POS_W),
		.ANGLE_WIDTH    (ANG_W),
		.CORDIC_STAGES  (STAGES)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin : watchdog
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	function automatic nav_t nav_from_pose(pose_t p);
		longint dx, dy, ax, ay, x, y, t, xs, ys;
		longint unsigned sq, r, rem, trial;
		logic [31:0] z, zr;
		nav_t n;
		dx = longint'(p.tx) - longint'(p.rx);
		dy = longint'(p.ty) - longint'(p.ry);
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		// digit-by-digit root, then round to nearest
		sq = ax * ax + ay * ay;
		r = 0;
		rem = 0;
		for (int k = 31; k >= 0; k--) begin
			rem = (rem << 2) | ((sq >> (2 * k)) & 64'd3);
			trial = (r << 2) | 64'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				r = (r << 1) | 64'd1;
			end else begin
				r = r << 1;
			end
		end
		if (rem > r)
			r++;
		n.range_q12 = (r > RANGE_MAX) ? '1 : r[POS_W:0];
		n.arrived = (ax < longint'(arrive_tol)) && (ay < longint'(arrive_tol));
		if (dx == 0 && dy == 0) begin
			n.turn = '0;
			n.degen = 1'b1;
		end else begin
			x = dx <<< GUARD;
			y = dy <<< GUARD;
			z = '0;
			// left half plane: pre-rotate by a quarter turn
			if (dx < 0) begin
				if (dy >= 0) begin
					t = x;
					x = y;
					y = -t;
					z = wbr_pkg::Z_POS_QUARTER;
				end else begin
					t = x;
					x = -y;
					y = t;
					z = wbr_pkg::Z_NEG_QUARTER;
				end
			end
			for (int i = 0; i < STAGES; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					z = z + atan_q31[i];
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - atan_q31[i];
				end
			end
			zr = z + (32'd1 << (31 - ANG_W));
			n.turn = zr[31:32-ANG_W] - p.yaw;
			n.degen = 1'b0;
		end
		return n;
	endfunction

	function automatic int draw_wait();
		return quiet ? 0 : int'($urandom_range(0, 5));
	endfunction

	function automatic pose_row_t mk_row(int rx, int ry, int yaw, int tx, int ty,
			bit typed = 1'b0, nav_t want = '0);
		pose_row_t row;
		row.pose.rx = POS_W'(rx);
		row.pose.ry = POS_W'(ry);
		row.pose.yaw = ANG_W'(yaw);
		row.pose.tx = POS_W'(tx);
		row.pose.ty = POS_W'(ty);
		row.typed = typed;
		row.want = want;
		return row;
	endfunction

	function automatic pose_t rand_pose();
		pose_t p;
		int span, dx, dy, edge_off;
		p.rx = POS_W'($urandom);
		p.ry = POS_W'($urandom);
		p.yaw = ANG_W'($urandom);
		p.tx = POS_W'($urandom);
		p.ty = POS_W'($urandom);
		span = (arrive_tol > 23'd4194303) ? 8388607 : 2 * int'(arrive_tol) + 4;
		dx = int'($urandom_range(0, 2 * span)) - span;
		dy = int'($urandom_range(0, 2 * span)) - span;
		edge_off = int'(arrive_tol) - int'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0, 1, 2: ;
			3, 4, 5, 6: begin
				p.tx = p.rx + POS_W'(dx);
				p.ty = p.ry + POS_W'(dy);
			end
			7: begin
				p.tx = p.rx;
				p.ty = p.ry;
			end
			8: begin
				p.tx = p.rx + ($urandom_range(0, 1) ? POS_W'(dx) : '0);
				p.ty = (p.tx == p.rx) ? p.ry + POS_W'(dy) : p.ry;
			end
			default: begin
				// offset right at the arrival boundary
				p.tx = p.rx + POS_W'($urandom_range(0, 1) ? edge_off : -edge_off);
				p.ty = p.ry + POS_W'(dy);
			end
		endcase
		if ($urandom_range(0, 15) == 0)
			p.yaw = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		return p;
	endfunction

	task automatic report(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch: %s", msg);
	endtask

	task automatic send_pose(pose_t p, bit typed, nav_t want);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {p.ty, p.tx, p.yaw, p.ry, p.rx};
		do @(posedge clk); while (!s_axis_tready);
		nav_due.push_back(typed ? want : nav_from_pose(p));
	endtask

	task automatic set_tolerance(logic [POS_W-2:0] tol);
		s_axis_tvalid <= 1'b0;
		while (nav_due.size() != 0) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= tol;
		@(posedge clk);
		arrive_tol = tol;
		cfg_wr_en <= 1'b0;
	endtask

	task automatic check_nav();
		nav_t want, got;
		got.turn = m_axis_tdata[ANG_W-1:0];
		got.range_q12 = m_axis_tdata[ANG_W+POS_W:ANG_W];
		got.arrived = m_axis_tdata[ANG_W+POS_W+1];
		got.degen = m_axis_tuser;
		if (nav_due.size() == 0) begin
			report($sformatf("transfer with nothing expected, data %h", m_axis_tdata));
			return;
		end
		want = nav_due.pop_front();
		if (got.turn !== want.turn)
			report($sformatf("turn_angle expected %0d got %0d",
				$signed(want.turn), $signed(got.turn)));
		if (got.range_q12 !== want.range_q12)
			report($sformatf("range expected %0d got %0d", want.range_q12, got.range_q12));
		if (got.arrived !== want.arrived)
			report($sformatf("at_target expected %b got %b", want.arrived, got.arrived));
		if (got.degen !== want.degen)
			report($sformatf("degenerate expected %b got %b", want.degen, got.degen));
	endtask

	initial begin : result_sink
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				check_nav();
				hold = draw_wait();
			end
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				hold--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		pose_row_t        rows [$];
		logic [POS_W-2:0] tol_plan [$];
		int               mx, mn;
		mx = 8388607;
		mn = -8388608;
		// same spot, then axes and quadrants, extremes, arrival boundaries, unit offsets, yaw cases
		rows.push_back(mk_row(0, 0, 0, 0, 0, 1'b1, NAV_SAME_SPOT));
		rows.push_back(mk_row(mx, mx, -32768, mx, mx, 1'b1, NAV_SAME_SPOT));
		rows.push_back(mk_row(mn, mn, 32767, mn, mn, 1'b1, NAV_SAME_SPOT));
		rows.push_back(mk_row(0, 0, 0, 4096, 0));
		rows.push_back(mk_row(0, 0, 0, -4096, 0));
		rows.push_back(mk_row(0, 0, 0, 0, 4096));
		rows.push_back(mk_row(0, 0, 0, 0, -4096));
		rows.push_back(mk_row(0, 0, 0, 3000, 5000));
		rows.push_back(mk_row(0, 0, 0, -3000, 5000));
		rows.push_back(mk_row(0, 0, 0, -3000, -5000));
		rows.push_back(mk_row(0, 0, 0, 3000, -5000));
		rows.push_back(mk_row(mn, mn, 0, mx, mx));
		rows.push_back(mk_row(mx, mx, 32767, mn, mn));
		rows.push_back(mk_row(mn, mx, -32768, mx, mn));
		rows.push_back(mk_row(mx, mn, 12345, mn, mx));
		rows.push_back(mk_row(500, 500, 100, 1523, -523));
		rows.push_back(mk_row(500, 500, 100, 1524, 500));
		rows.push_back(mk_row(-500, 0, -100, -1523, 1024));
		rows.push_back(mk_row(-500, 0, -100, -1524, -1023));
		rows.push_back(mk_row(0, 0, 0, -1, 0));
		rows.push_back(mk_row(0, 0, 0, -1, -1));
		rows.push_back(mk_row(0, 0, 0, 1, 1));
		rows.push_back(mk_row(0, 0, 16384, 0, 4096));
		rows.push_back(mk_row(100, -200, -1, mn, mx));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_pose(rows[i].pose, rows[i].typed, rows[i].want);

		tol_plan = '{23'd0, 23'h7F_FFFF, 23'd1, 23'($urandom_range(2, 8388606)),
			23'($urandom_range(2, 20000))};
		foreach (tol_plan[j]) begin
			set_tolerance(tol_plan[j]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0)
					quiet = ($urandom_range(0, 3) == 0);
				send_pose(rand_pose(), 1'b0, '0);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (nav_due.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
